// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/htld_pkg.sv =====
package htld_pkg;

    localparam int MAX_LEAVES_DEF = 256;
    localparam int NODE_SLOTS_DEF = 512;

    typedef enum logic [1:0] {
        OP_SHAPE = 2'd0,
        OP_MSG   = 2'd1,
        OP_START = 2'd2
    } op_t;

endpackage

// ===== design/huffman_tree_load_and_decode.sv =====
// Huffman tree loader and decoder.
// Input channel (in_valid/in_ready) carries one beat per item: op selects a
// tree shape bit (with leaf_char for a leaf), a message bit, or the start of
// a new tree. Shape bits arrive in pre-order; message bits sent before the
// tree is complete are dropped.
// Output channel (out_valid/out_ready) carries one decoded byte per beat,
// produced when a message bit reaches a leaf.
// Throughput: one input beat per cycle. Each message bit does one read of
// the node table, whose read port is registered, and the next bit's address
// is formed from that registered entry, so bits stream back to back.
// Output path: a message bit's node entry is registered as the bit is taken,
// then its symbol moves to the result register when the output is free.
// Reset: the tree is empty with the root pending, no output is held. The
// node table and the pending stack are not cleared; they are always written
// before what they hold is used.
// Stall: a waiting symbol holds on the output. New beats are still taken
// while the result register is free or being drained; a message bit that is
// about to emit while the result register is blocked holds in_ready low.
module huffman_tree_load_and_decode #(
    parameter int MAX_LEAVES = htld_pkg::MAX_LEAVES_DEF,
    parameter int NODE_SLOTS = htld_pkg::NODE_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic       bit_req,
    input  logic [7:0] leaf_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] symbol
);
    import htld_pkg::*;

    localparam int NODE_W = $clog2(NODE_SLOTS);
    localparam int NCNT_W = $clog2(NODE_SLOTS + 1);
    localparam int SIDX_W = $clog2(MAX_LEAVES);
    localparam int SCNT_W = $clog2(MAX_LEAVES + 1);

    typedef struct packed {
        logic              leaf;
        logic [7:0]        sym;
        logic [NODE_W-1:0] fc;
    } node_t;

    node_t             node_mem  [NODE_SLOTS];
    logic [NODE_W-1:0] stack_mem [MAX_LEAVES];

    logic [NCNT_W-1:0] nodes_used_reg, nodes_used_next;
    logic [SCNT_W-1:0] stack_count_reg, stack_count_next;
    logic [NODE_W-1:0] top_reg, top_next;
    logic [NODE_W-1:0] below_reg;
    logic              tree_done_reg, tree_done_next;
    logic              root_leaf_reg, root_leaf_next;
    logic [NODE_W-1:0] root_fc_reg, root_fc_next;
    logic              cur_root_reg, cur_root_next;
    logic [NODE_W-1:0] cur_fc_reg, cur_fc_next;
    logic              s1_walk_reg, s1_walk_next;
    node_t             rdata_reg;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        symbol_reg, symbol_next;

    logic              accept;
    logic              eff_root;
    logic [NODE_W-1:0] eff_fc;
    logic              s1_emit;
    logic              s1_adv;
    logic              node_we;
    node_t             node_wdata;
    logic              node_re;
    logic [NODE_W-1:0] node_raddr;
    logic              stack_push;
    logic              stack_pop;
    logic [SIDX_W-1:0] stack_waddr;
    logic [NODE_W-1:0] stack_wdata;
    logic [SIDX_W-1:0] stack_raddr;
    logic [SCNT_W-1:0] cnt_m1;
    logic [SCNT_W-1:0] cnt_m3;
    logic [NODE_W-1:0] nu_idx;
    logic              room;

    // While a walk read is in flight, the cursor is the node just fetched,
    // or the root again if that node is a leaf.
    assign eff_root = s1_walk_reg ? rdata_reg.leaf : cur_root_reg;
    assign eff_fc   = s1_walk_reg ? rdata_reg.fc   : cur_fc_reg;
    assign s1_emit  = s1_walk_reg && rdata_reg.leaf;
    assign s1_adv   = s1_walk_reg && (!s1_emit || !out_valid_reg || out_ready);
    assign in_ready = !s1_walk_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign cnt_m1      = stack_count_reg - SCNT_W'(1);
    assign cnt_m3      = stack_count_reg - SCNT_W'(3);
    assign stack_waddr = cnt_m1[SIDX_W-1:0];
    assign stack_raddr = cnt_m3[SIDX_W-1:0];
    assign nu_idx      = nodes_used_reg[NODE_W-1:0];
    assign stack_wdata = nu_idx + NODE_W'(1);
    assign room        = (({1'b0, nodes_used_reg} + (NCNT_W + 1)'(2))
                          <= (NCNT_W + 1)'(NODE_SLOTS))
                         && (stack_count_reg < SCNT_W'(MAX_LEAVES));

    always_comb
    begin
        nodes_used_next  = nodes_used_reg;
        stack_count_next = stack_count_reg;
        top_next         = top_reg;
        tree_done_next   = tree_done_reg;
        root_leaf_next   = root_leaf_reg;
        root_fc_next     = root_fc_reg;
        cur_root_next    = cur_root_reg;
        cur_fc_next      = cur_fc_reg;
        s1_walk_next     = s1_walk_reg;
        out_valid_next   = out_valid_reg;
        symbol_next      = symbol_reg;
        node_we          = 1'b0;
        node_wdata       = '0;
        node_re          = 1'b0;
        node_raddr       = '0;
        stack_push       = 1'b0;
        stack_pop        = 1'b0;

        if (s1_adv && s1_emit)
        begin
            out_valid_next = 1'b1;
            symbol_next    = rdata_reg.sym;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            cur_root_next = eff_root;
            cur_fc_next   = eff_fc;
            s1_walk_next  = 1'b0;
        end

        if (accept)
        begin
            case (op_t'(op))
                OP_SHAPE:
                begin
                    if (!tree_done_reg)
                    begin
                        if (!bit_req)
                        begin
                            node_we          = 1'b1;
                            node_wdata.leaf  = 1'b1;
                            node_wdata.sym   = leaf_char;
                            stack_pop        = 1'b1;
                            stack_count_next = cnt_m1;
                            top_next         = below_reg;
                            if (top_reg == '0)
                            begin
                                root_leaf_next = 1'b1;
                            end
                            if (stack_count_reg == SCNT_W'(1))
                            begin
                                tree_done_next = 1'b1;
                                cur_root_next  = 1'b1;
                            end
                        end
                        else if (room)
                        begin
                            node_we          = 1'b1;
                            node_wdata.leaf  = 1'b0;
                            node_wdata.fc    = nu_idx;
                            stack_push       = 1'b1;
                            stack_count_next = stack_count_reg + SCNT_W'(1);
                            nodes_used_next  = nodes_used_reg + NCNT_W'(2);
                            top_next         = nu_idx;
                            if (top_reg == '0)
                            begin
                                root_leaf_next = 1'b0;
                                root_fc_next   = nu_idx;
                            end
                        end
                    end
                end
                OP_MSG:
                begin
                    if (tree_done_reg)
                    begin
                        node_re      = 1'b1;
                        s1_walk_next = 1'b1;
                        // A leaf root is fetched itself, so every bit emits it.
                        if (eff_root && root_leaf_reg)
                        begin
                            node_raddr = '0;
                        end
                        else
                        begin
                            node_raddr = (eff_root ? root_fc_reg : eff_fc)
                                         + NODE_W'(bit_req);
                        end
                    end
                end
                OP_START:
                begin
                    nodes_used_next  = NCNT_W'(1);
                    stack_count_next = SCNT_W'(1);
                    top_next         = '0;
                    tree_done_next   = 1'b0;
                    cur_root_next    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_used_reg  <= NCNT_W'(1);
            stack_count_reg <= SCNT_W'(1);
            top_reg         <= '0;
            tree_done_reg   <= 1'b0;
            root_leaf_reg   <= 1'b0;
            root_fc_reg     <= '0;
            cur_root_reg    <= 1'b1;
            cur_fc_reg      <= '0;
            s1_walk_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            nodes_used_reg  <= nodes_used_next;
            stack_count_reg <= stack_count_next;
            top_reg         <= top_next;
            tree_done_reg   <= tree_done_next;
            root_leaf_reg   <= root_leaf_next;
            root_fc_reg     <= root_fc_next;
            cur_root_reg    <= cur_root_next;
            cur_fc_reg      <= cur_fc_next;
            s1_walk_reg     <= s1_walk_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[top_reg] <= node_wdata;
        end
        if (node_re)
        begin
            rdata_reg <= node_mem[node_raddr];
        end
    end

    // The top of the pending stack lives in top_reg and the entry under it in
    // below_reg; the memory holds everything beneath the top.
    always_ff @(posedge clk)
    begin
        if (stack_push)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_push)
        begin
            below_reg <= stack_wdata;
        end
        else if (stack_pop)
        begin
            below_reg <= stack_mem[stack_raddr];
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;

endmodule

// ===== design/htld_checker.sv =====
`include "assert_macros.svh"

module htld_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] op,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] symbol
);
    import htld_pkg::*;

    // A blocked output beat keeps its byte.
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(symbol), "output beat changed while stalled")

    // With the result register empty, nothing can hold the input back.
    `ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

    // A fresh symbol always comes from an earlier accepted message bit.
    `ASSERT_IMPL(a_sym_from_msg, $rose(out_valid), $past(in_valid && in_ready && (op == OP_MSG), 2), "symbol without a message bit")

endmodule

bind huffman_tree_load_and_decode htld_checker u_htld_checker (.*);
